>>> src/svrg_pkg.sv
// Package for the SVRG gradient-difference block: widths, command codes,
// fixed-point limits and the sigmoid table generator. No dependencies.
package svrg_pkg;

  localparam int FEATURE_COUNT_DEF   = 4096;
  localparam int MAX_NONZEROS_DEF    = 64;
  localparam int SIGMOID_ENTRIES_DEF = 256;

  localparam int IDX_W = 12;
  localparam int WGT_W = 24;
  localparam int VAL_W = 16;
  localparam int ACC_W = 40;
  localparam int DOT_W = 48;
  localparam int SIG_W = 16;

  typedef enum logic [1:0] {
    CMD_LOAD_CUR  = 2'd0,
    CMD_LOAD_SNAP = 2'd1,
    CMD_SAMPLE    = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DOT_W-1:0] DOT_HI  = (48'sd8 <<< 28) - 48'sd1;
  localparam logic signed [DOT_W-1:0] DOT_LO  = -(48'sd8 <<< 28);

  // Shift-subtract quotient, for table generation only.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned q);
    longint unsigned rem, quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((n >> b) & 64'd1);
      quo = quo << 1;
      if (rem >= q) begin
        rem = rem - q;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // Elaboration-time table entry.
  function automatic logic [SIG_W-1:0] sig_entry(input int k, input int entries);
    longint unsigned num0, y, z, term, r, e, d, num, v;
    longint sum, xq;
    num0 = udiv(longint'(2 * k + 1) << 33, longint'(entries));
    xq   = longint'(num0) - (longint'(8) << 30);
    y    = (xq < 0) ? longint'(-xq) : xq;
    z    = y >> 6;
    term = 64'd1 << 30;
    sum  = longint'(1) << 30;
    for (int i = 1; i <= 8; i++) begin
      term = udiv((term * z) >> 30, longint'(i));
      if ((i & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    r = sum;
    for (int i = 0; i < 6; i++) r = (r * r) >> 30;
    e   = r;
    d   = (64'd1 << 30) + e;
    num = (xq >= 0) ? (64'd1 << 46) : (e << 16);
    v   = udiv(num + (d >> 1), d);
    return (v > 64'd65535) ? 16'hFFFF : v[SIG_W-1:0];
  endfunction

  typedef struct packed {
    logic                    go;
    logic                    clear;
    logic signed [VAL_W-1:0] val;
    logic signed [SIG_W:0]   diff;
  } acc_op_t;

endpackage

>>> src/svrg_sigmoid.sv
// Sigmoid table lookup with clamp of a Q20.28 dot product; registered output.
// Depends on svrg_pkg.
module svrg_sigmoid #(
  parameter int SIGMOID_ENTRIES = svrg_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic signed [svrg_pkg::DOT_W-1:0]   dot,
  output logic        [svrg_pkg::SIG_W-1:0]   sig
);
  localparam int SIW = $clog2(SIGMOID_ENTRIES);
  logic [svrg_pkg::SIG_W-1:0] rom [SIGMOID_ENTRIES];
  logic signed [svrg_pkg::DOT_W-1:0] c;
  logic [31:0] t;
  logic [31+SIW:0] p;

  for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
    localparam logic [svrg_pkg::SIG_W-1:0] ENTRY = svrg_pkg::sig_entry(k, SIGMOID_ENTRIES);
    assign rom[k] = ENTRY;
  end

  always_comb begin
    c = dot;
    if (dot < svrg_pkg::DOT_LO) c = svrg_pkg::DOT_LO;
    if (dot > svrg_pkg::DOT_HI) c = svrg_pkg::DOT_HI;
    t = 32'(c - svrg_pkg::DOT_LO);
    p = (32+SIW)'(t) * (32+SIW)'(SIGMOID_ENTRIES);
  end

  always_ff @(posedge clk) begin
    sig <= rom[p[31+SIW:32]];
  end
endmodule

>>> src/svrg_accum.sv
// Accumulator memory with one shared multiply-add; used for sample walk,
// reads and the clearing pass. Depends on svrg_pkg.
module svrg_accum #(
  parameter int FEATURE_COUNT = svrg_pkg::FEATURE_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic [$clog2(FEATURE_COUNT)-1:0]     rd_addr,
  output logic signed [svrg_pkg::ACC_W-1:0]    rd_data,
  input  logic [$clog2(FEATURE_COUNT)-1:0]     wr_addr,
  input  svrg_pkg::acc_op_t                    op
);
  localparam int PW = svrg_pkg::VAL_W + svrg_pkg::SIG_W + 1;
  logic signed [svrg_pkg::ACC_W-1:0] mem [FEATURE_COUNT];
  logic signed [PW-1:0] prod;
  logic signed [svrg_pkg::ACC_W:0] sum;
  logic signed [svrg_pkg::ACC_W-1:0] wdata;

  always_comb begin
    prod = PW'(op.val) * PW'(op.diff);
    sum  = (svrg_pkg::ACC_W+1)'(rd_data) + (svrg_pkg::ACC_W+1)'(prod);
    if (op.clear) wdata = '0;
    else if (sum > (svrg_pkg::ACC_W+1)'(svrg_pkg::ACC_MAX)) wdata = svrg_pkg::ACC_MAX;
    else if (sum < (svrg_pkg::ACC_W+1)'(svrg_pkg::ACC_MIN)) wdata = svrg_pkg::ACC_MIN;
    else wdata = sum[svrg_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (op.go) mem[wr_addr] <= wdata;
  end
endmodule

>>> src/svrg_gradient_difference.sv
// Top level of the SVRG gradient-difference block: sequencer, weight and
// sample memories, dot products and read scaling. Depends on svrg_pkg.
//
// Usage: drive command and fields with start high while busy is low; the
// item is taken at that edge. Loads (commands 0,1) write a current or
// snapshot weight. A sample element passes through weight read, multiply
// and add. The last element of a sample then adds the sigmoid lookup and,
// per buffered element, an accumulator read-modify-write.
// A read (command 3) passes through memory read, two partial products,
// round and saturate; its result is on the strobe in the cycle after that,
// and the entry is cleared.
// update_scale is written through cfg_valid/cfg_ready whenever cfg_valid.
// After reset the block clears the accumulator memory one entry a cycle,
// all entries, with busy high. The receiver cannot stall: strobe
// marks a result for exactly one cycle.
module svrg_gradient_difference #(
  parameter int FEATURE_COUNT   = svrg_pkg::FEATURE_COUNT_DEF,
  parameter int MAX_NONZEROS    = svrg_pkg::MAX_NONZEROS_DEF,
  parameter int SIGMOID_ENTRIES = svrg_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command,
  input  logic [svrg_pkg::IDX_W-1:0]          feature_index,
  input  logic signed [svrg_pkg::WGT_W-1:0]   weight_value,
  input  logic signed [svrg_pkg::VAL_W-1:0]   feature_value,
  input  logic                                last_in_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [31:0]                         cfg_data,
  output logic                                strobe,
  output logic [svrg_pkg::IDX_W-1:0]          result_index,
  output logic signed [svrg_pkg::WGT_W-1:0]   update_value,
  output logic                                was_saturated,
  output logic                                sample_overflow
);
  localparam int FW = $clog2(FEATURE_COUNT);
  localparam int BW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int CW = $clog2(MAX_NONZEROS + 1);
  localparam int ACC_W = svrg_pkg::ACC_W;
  localparam int DOT_W = svrg_pkg::DOT_W;
  localparam int XW = svrg_pkg::IDX_W + 1;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LOAD  = 11'b00000000100,
    S_WRD   = 11'b00000001000,
    S_DOT   = 11'b00000010000,
    S_SIG   = 11'b00000100000,
    S_WALK  = 11'b00001000000,
    S_UPD   = 11'b00010000000,
    S_RD    = 11'b00100000000,
    S_MUL   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  // Reduce a feature number by compare and subtract of shifted feature counts.
  function automatic logic [FW-1:0] wrap_index(input logic [svrg_pkg::IDX_W-1:0] f);
    logic [XW-1:0] x;
    x = {1'b0, f};
    for (int s = svrg_pkg::IDX_W - 1; s >= 0; s--) begin
      if ((longint'(FEATURE_COUNT) << s) < (longint'(1) << svrg_pkg::IDX_W)) begin
        if (x >= XW'(longint'(FEATURE_COUNT) << s)) x = x - XW'(longint'(FEATURE_COUNT) << s);
      end
    end
    return FW'(x);
  endfunction

  state_t state, state_next;

  logic signed [svrg_pkg::WGT_W-1:0] cur_mem  [FEATURE_COUNT];
  logic signed [svrg_pkg::WGT_W-1:0] snap_mem [FEATURE_COUNT];
  logic [FW-1:0]                     bidx_mem [MAX_NONZEROS];
  logic signed [svrg_pkg::VAL_W-1:0] bval_mem [MAX_NONZEROS];

  logic [1:0]                        cmd;
  logic [FW-1:0]                     fidx;
  logic signed [svrg_pkg::WGT_W-1:0] wval;
  logic signed [svrg_pkg::VAL_W-1:0] fval;
  logic                              last;
  logic [31:0]                       update_scale;
  logic [CW-1:0]                     count;
  logic [BW-1:0]                     walk;
  logic [BW-1:0]                     rd_ptr;
  logic [2:0]                        sigwait;
  logic signed [DOT_W-1:0]           dot_cur, dot_snap;
  logic signed [svrg_pkg::WGT_W-1:0] wcur, wsnap;
  logic signed [39:0]                pcur, psnap;
  logic [FW-1:0]                     clr_addr, acc_addr, acc_waddr;
  logic [FW-1:0]                     bidx_q;
  logic signed [svrg_pkg::VAL_W-1:0] bval_q;
  logic [svrg_pkg::SIG_W-1:0]        sig_cur, sig_snap;
  logic signed [svrg_pkg::SIG_W:0]   diff;
  logic signed [ACC_W-1:0]           acc_rd;
  logic [ACC_W-1:0]                  mag;
  logic                              neg;
  logic [55:0]                       ph, pl;
  svrg_pkg::acc_op_t                 op;
  logic [56:0]                       msum;
  logic [28:0]                       m;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_ptr    = (state == S_UPD) ? walk + BW'(1) : walk;

  always_ff @(posedge clk) begin
    if (rst) update_scale <= '0;
    else if (cfg_valid && cfg_ready) update_scale <= cfg_data;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == FW'(FEATURE_COUNT - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (svrg_pkg::cmd_t'(command))
            svrg_pkg::CMD_SAMPLE: state_next = S_WRD;
            svrg_pkg::CMD_READ:   state_next = S_RD;
            default:              state_next = S_LOAD;
          endcase
        end
      end
      S_LOAD: state_next = S_IDLE;
      S_WRD:  state_next = S_DOT;
      S_DOT:  state_next = last ? S_SIG : S_IDLE;
      S_SIG: begin
        if (sigwait == 3'd2) state_next = (count == '0) ? S_IDLE : S_WALK;
      end
      S_WALK: state_next = S_UPD;
      S_UPD:  state_next = (CW'(walk) + CW'(1) >= count) ? S_IDLE : S_WALK;
      S_RD:   state_next = S_MUL;
      S_MUL:  state_next = S_OUT;
      S_OUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      count           <= '0;
      walk            <= '0;
      sigwait         <= '0;
      dot_cur         <= '0;
      dot_snap        <= '0;
      sample_overflow <= 1'b0;
      strobe          <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == S_OUT);
      if (state == S_CLEAR) clr_addr <= clr_addr + FW'(1);
      if (state == S_IDLE) walk <= '0;
      if (state == S_SIG) sigwait <= sigwait + 3'd1;
      else sigwait <= '0;
      if (state == S_DOT) begin
        if (count < CW'(MAX_NONZEROS)) begin
          count    <= count + CW'(1);
          dot_cur  <= dot_cur + DOT_W'(pcur);
          dot_snap <= dot_snap + DOT_W'(psnap);
        end else begin
          sample_overflow <= 1'b1;
        end
      end
      if (state == S_SIG && state_next != S_SIG) begin
        dot_cur  <= '0;
        dot_snap <= '0;
        if (count == '0) count <= '0;
      end
      if (state == S_UPD) begin
        walk <= walk + BW'(1);
        if (state_next == S_IDLE) count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd  <= command;
      fidx <= wrap_index(feature_index);
      wval <= weight_value;
      fval <= feature_value;
      last <= last_in_sample;
    end
    if (state == S_LOAD) begin
      if (cmd == svrg_pkg::CMD_LOAD_CUR) cur_mem[fidx] <= wval;
      else snap_mem[fidx] <= wval;
    end
    wcur  <= cur_mem[fidx];
    wsnap <= snap_mem[fidx];
    if (state == S_WRD && count < CW'(MAX_NONZEROS)) begin
      bidx_mem[BW'(count)] <= fidx;
      bval_mem[BW'(count)] <= fval;
    end
    bidx_q <= bidx_mem[rd_ptr];
    bval_q <= bval_mem[rd_ptr];
    if (state == S_SIG && sigwait == 3'd1) diff <= {1'b0, sig_snap} - {1'b0, sig_cur};
  end

  always_comb begin
    pcur  = 40'(wcur) * 40'(fval);
    psnap = 40'(wsnap) * 40'(fval);
  end

  svrg_sigmoid #(.SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_sig_cur (
    .clk(clk), .dot(dot_cur), .sig(sig_cur));
  svrg_sigmoid #(.SIGMOID_ENTRIES(SIGMOID_ENTRIES)) u_sig_snap (
    .clk(clk), .dot(dot_snap), .sig(sig_snap));

  always_comb begin
    acc_addr  = fidx;
    acc_waddr = fidx;
    op.go     = 1'b0;
    op.clear  = 1'b0;
    op.val    = bval_q;
    op.diff   = diff;
    case (state)
      S_CLEAR: begin
        acc_waddr = clr_addr;
        op.go     = 1'b1;
        op.clear  = 1'b1;
      end
      S_WALK: acc_addr = bidx_q;
      S_UPD: begin
        acc_addr  = bidx_q;
        acc_waddr = bidx_q;
        op.go     = 1'b1;
      end
      S_MUL: begin
        op.go    = 1'b1;
        op.clear = 1'b1;
      end
      default: ;
    endcase
  end

  svrg_accum #(.FEATURE_COUNT(FEATURE_COUNT)) u_acc (
    .clk(clk), .rd_addr(acc_addr), .rd_data(acc_rd), .wr_addr(acc_waddr), .op(op));

  always_comb begin
    mag = acc_rd[ACC_W-1] ? ACC_W'(-acc_rd) : ACC_W'(acc_rd);
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      neg <= acc_rd[ACC_W-1];
      ph  <= 56'(mag) * 56'(update_scale[31:16]);
      pl  <= 56'(mag) * 56'(update_scale[15:0]);
    end
  end

  always_comb begin
    msum = 57'(ph) + 57'(pl >> 16) + (57'd1 << 27);
    m    = (msum[56:28] > 29'(8388608)) ? 29'(8388608) : msum[56:28];
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      result_index <= svrg_pkg::IDX_W'(fidx);
      if (neg) begin
        update_value  <= svrg_pkg::WGT_W'(-$signed({1'b0, m}));
        was_saturated <= (msum[56:28] > 29'(8388608));
      end else begin
        update_value  <= (msum[56:28] > 29'(8388607)) ? 24'sd8388607 : svrg_pkg::WGT_W'(m);
        was_saturated <= (msum[56:28] > 29'(8388607));
      end
    end
  end

  a_busy_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");
  a_strobe_after_out: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == S_OUT))
    else $error("strobe without read");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_NONZEROS))
    else $error("buffer count beyond depth");
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(sample_overflow) |-> sample_overflow)
    else $error("overflow flag cleared");
endmodule
